// ----- rtl/core/quoted_string_escape_decoder_unit_assert.svh -----
// Assertion macros shared by the RTL.
`ifndef QUOTED_STRING_ESCAPE_DECODER_UNIT_ASSERT_SVH
`define QUOTED_STRING_ESCAPE_DECODER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define QSED_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define QSED_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");
`else
`define QSED_ASSERT(label, clk, rst_n, prop)
`define QSED_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ----- rtl/core/qsed_pkg.sv -----
`timescale 1ns / 1ps
package qsed_pkg;

  localparam int QSED_JOB_DEPTH = 4;

  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_DATA   = 2'd1;
  localparam logic [1:0] OP_EOL    = 2'd2;
  localparam logic [1:0] OP_IGNORE = 2'd3;

  localparam logic [3:0] ST_BYTE       = 4'd0;
  localparam logic [3:0] ST_CLOSED     = 4'd1;
  localparam logic [3:0] ST_UNTERM     = 4'd2;
  localparam logic [3:0] ST_BAD_ESC    = 4'd3;
  localparam logic [3:0] ST_BAD_X      = 4'd4;
  localparam logic [3:0] ST_BAD_U      = 4'd5;
  localparam logic [3:0] ST_BAD_LOW    = 4'd6;
  localparam logic [3:0] ST_BAD_PAIR   = 4'd7;
  localparam logic [3:0] ST_LONE_HIGH  = 4'd8;
  localparam logic [3:0] ST_LONE_LOW   = 4'd9;
  localparam logic [3:0] ST_BAD_BIG_U  = 4'd10;
  localparam logic [3:0] ST_BAD_CP     = 4'd11;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [3:0] status;
    logic       last_of_run;
  } out_item_t;

  typedef enum logic [1:0] {
    JOB_RAW,
    JOB_CP,
    JOB_STAT
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [20:0] value;
    logic [3:0]  status;
  } job_t;

  function automatic logic [1:0] utf8_len_m1(input logic [20:0] cp);
    logic [1:0] n;
    if (cp < 21'h80) n = 2'd0;
    else if (cp < 21'h800) n = 2'd1;
    else if (cp < 21'h10000) n = 2'd2;
    else n = 2'd3;
    return n;
  endfunction

  function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] len_m1,
                                           input logic [1:0] idx);
    logic [7:0] b;
    b = 8'h00;
    case (len_m1)
      2'd0: b = cp[7:0];
      2'd1: b = (idx == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
      2'd2: begin
        case (idx)
          2'd0: b = {4'b1110, cp[15:12]};
          2'd1: b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      default: begin
        case (idx)
          2'd0: b = {5'b11110, cp[20:18]};
          2'd1: b = {2'b10, cp[17:12]};
          2'd2: b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
    endcase
    return b;
  endfunction

endpackage

// ----- rtl/core/qsed_front.sv -----
`timescale 1ns / 1ps
module qsed_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  qsed_pkg::in_item_t item,
  output logic              job_valid,
  output qsed_pkg::job_t    job
);
  import qsed_pkg::*;

  typedef enum logic [2:0] {
    M_IDLE,
    M_TEXT,
    M_ESC,
    M_HEX,
    M_HI,
    M_HI_BS,
    M_LOW
  } mode_t;

  typedef enum logic [1:0] {
    ESC_X,
    ESC_U,
    ESC_BIG_U
  } esc_t;

  mode_t       mode_r, mode_nxt;
  esc_t        esc_r, esc_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [9:0]  held_r, held_nxt;
  logic        pend_r, pend_nxt;

  logic [4:0]  digit;
  logic [31:0] acc_sh;
  logic [3:0]  cnt_inc;
  logic [3:0]  need;
  logic [3:0]  digit_err;
  logic [7:0]  b;
  logic [10:0] plane;

  assign b       = item.data_byte;
  assign acc_sh  = {acc_r[27:0], digit[3:0]};
  assign cnt_inc = cnt_r + 4'd1;
  assign plane   = {1'b0, held_r} + 11'd64;

  always_comb begin
    if (b >= 8'h30 && b <= 8'h39) digit = {1'b0, b[3:0]};
    else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46))
      digit = {1'b0, b[3:0] + 4'd9};
    else digit = 5'h10;
  end

  always_comb begin
    unique case (esc_r)
      ESC_U:     begin need = 4'd4; digit_err = ST_BAD_U;     end
      ESC_BIG_U: begin need = 4'd8; digit_err = ST_BAD_BIG_U; end
      default:   begin need = 4'd2; digit_err = ST_BAD_X;     end
    endcase
  end

  always_comb begin
    mode_nxt  = mode_r;
    esc_nxt   = esc_r;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    held_nxt  = held_r;
    pend_nxt  = pend_r;
    job_valid = 1'b0;
    job       = '{kind: JOB_STAT, value: '0, status: ST_BYTE};
    if (accept) begin
      unique case (item.operation)
        OP_START: begin
          mode_nxt = M_TEXT;
          esc_nxt  = ESC_X;
          cnt_nxt  = '0;
          acc_nxt  = '0;
          held_nxt = '0;
          pend_nxt = 1'b0;
        end
        OP_EOL: begin
          if (mode_r != M_IDLE) begin
            job_valid = 1'b1;
            mode_nxt  = M_IDLE;
            unique case (mode_r)
              M_TEXT, M_ESC: job.status = ST_UNTERM;
              M_HEX:         job.status = digit_err;
              default:       job.status = ST_LONE_HIGH;
            endcase
          end
        end
        OP_DATA: begin
          unique case (mode_r)
            M_TEXT: begin
              if (b == 8'h22) begin
                job_valid  = 1'b1;
                job.status = ST_CLOSED;
                mode_nxt   = M_IDLE;
              end else if (b == 8'h5C) begin
                mode_nxt = M_ESC;
              end else begin
                job_valid = 1'b1;
                job.kind  = JOB_RAW;
                job.value = {13'd0, b};
              end
            end
            M_ESC: begin
              job_valid = 1'b1;
              job.kind  = JOB_CP;
              mode_nxt  = M_TEXT;
              unique case (b)
                8'h30: job.value = 21'h00;
                8'h61: job.value = 21'h07;
                8'h62: job.value = 21'h08;
                8'h74: job.value = 21'h09;
                8'h6E: job.value = 21'h0A;
                8'h76: job.value = 21'h0B;
                8'h66: job.value = 21'h0C;
                8'h72: job.value = 21'h0D;
                8'h22: job.value = 21'h22;
                8'h2F: job.value = 21'h2F;
                8'h5C: job.value = 21'h5C;
                8'h78, 8'h75, 8'h55: begin
                  job_valid = 1'b0;
                  esc_nxt   = (b == 8'h78) ? ESC_X : ((b == 8'h75) ? ESC_U : ESC_BIG_U);
                  cnt_nxt   = '0;
                  acc_nxt   = '0;
                  mode_nxt  = M_HEX;
                end
                default: begin
                  job.kind   = JOB_STAT;
                  job.status = ST_BAD_ESC;
                  mode_nxt   = M_IDLE;
                end
              endcase
            end
            M_HEX: begin
              if (digit[4]) begin
                job_valid  = 1'b1;
                job.status = digit_err;
                mode_nxt   = M_IDLE;
              end else begin
                acc_nxt = acc_sh;
                cnt_nxt = cnt_inc;
                if (cnt_inc >= need) begin
                  unique case (esc_r)
                    ESC_U: begin
                      if (acc_sh >= 32'hD800 && acc_sh <= 32'hDBFF) begin
                        held_nxt = acc_sh[9:0];
                        mode_nxt = M_HI;
                      end else if (acc_sh >= 32'hDC00 && acc_sh <= 32'hDFFF) begin
                        job_valid  = 1'b1;
                        job.status = ST_LONE_LOW;
                        mode_nxt   = M_IDLE;
                      end else begin
                        job_valid = 1'b1;
                        job.kind  = JOB_CP;
                        job.value = acc_sh[20:0];
                        mode_nxt  = M_TEXT;
                      end
                    end
                    ESC_BIG_U: begin
                      job_valid = 1'b1;
                      if (acc_sh > 32'h10FFFF || (acc_sh >= 32'hD800 && acc_sh <= 32'hDFFF)) begin
                        job.status = ST_BAD_CP;
                        mode_nxt   = M_IDLE;
                      end else begin
                        job.kind  = JOB_CP;
                        job.value = acc_sh[20:0];
                        mode_nxt  = M_TEXT;
                      end
                    end
                    default: begin
                      job_valid = 1'b1;
                      job.kind  = JOB_CP;
                      job.value = {13'd0, acc_sh[7:0]};
                      mode_nxt  = M_TEXT;
                    end
                  endcase
                end
              end
            end
            M_HI: begin
              if (b != 8'h5C) begin
                job_valid  = 1'b1;
                job.status = ST_LONE_HIGH;
                mode_nxt   = M_IDLE;
              end else begin
                mode_nxt = M_HI_BS;
              end
            end
            M_HI_BS: begin
              if (b != 8'h75) begin
                job_valid  = 1'b1;
                job.status = ST_LONE_HIGH;
                mode_nxt   = M_IDLE;
              end else begin
                cnt_nxt  = '0;
                acc_nxt  = '0;
                pend_nxt = 1'b0;
                mode_nxt = M_LOW;
              end
            end
            M_LOW: begin
              if (digit[4]) pend_nxt = 1'b1;
              else acc_nxt = acc_sh;
              cnt_nxt = cnt_inc;
              if (cnt_inc >= 4'd4) begin
                job_valid = 1'b1;
                if (pend_r || digit[4]) begin
                  job.status = ST_BAD_LOW;
                  mode_nxt   = M_IDLE;
                end else if (acc_sh < 32'hDC00 || acc_sh > 32'hDFFF) begin
                  job.status = ST_BAD_PAIR;
                  mode_nxt   = M_IDLE;
                end else begin
                  job.kind  = JOB_CP;
                  job.value = {plane, acc_sh[9:0]};
                  mode_nxt  = M_TEXT;
                end
              end
            end
            default: mode_nxt = M_IDLE;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      esc_r  <= ESC_X;
      cnt_r  <= '0;
      acc_r  <= '0;
      held_r <= '0;
      pend_r <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      esc_r  <= esc_nxt;
      cnt_r  <= cnt_nxt;
      acc_r  <= acc_nxt;
      held_r <= held_nxt;
      pend_r <= pend_nxt;
    end
  end

endmodule

// ----- rtl/core/qsed_fifo.sv -----
`timescale 1ns / 1ps
`include "quoted_string_escape_decoder_unit_assert.svh"
module qsed_fifo #(
  parameter int DEPTH = qsed_pkg::QSED_JOB_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  qsed_pkg::job_t wr_job,
  output logic           full,
  input  logic           rd_en,
  output logic           empty,
  output qsed_pkg::job_t rd_job
);
  import qsed_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_wr, do_rd;

  assign full   = (count_r == CW'(DEPTH));
  assign empty  = (count_r == '0);
  assign rd_job = mem_r[rd_ptr_r];
  assign do_wr  = wr_en && !full;
  assign do_rd  = rd_en && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    if (do_rd) rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    if (do_wr && !do_rd) count_nxt = count_r + CW'(1);
    else if (do_rd && !do_wr) count_nxt = count_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wr_ptr_r] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `QSED_ASSERT(a_count_bound, clk, rst_n, count_r <= CW'(DEPTH))
  `QSED_ASSERT(a_no_write_full, clk, rst_n, !(wr_en && full))
  `QSED_ASSERT(a_ptr_agree, clk, rst_n, (count_r == '0 || count_r == CW'(DEPTH)) |-> wr_ptr_r == rd_ptr_r)

endmodule

// ----- rtl/core/qsed_back.sv -----
`timescale 1ns / 1ps
`include "quoted_string_escape_decoder_unit_assert.svh"
module qsed_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                job_avail,
  input  qsed_pkg::job_t      job,
  output logic                job_take,
  output logic                out_valid,
  input  logic                out_take,
  output qsed_pkg::out_item_t out_item
);
  import qsed_pkg::*;

  logic [1:0] idx_r, idx_nxt;
  logic       valid_r, valid_nxt;
  out_item_t  out_r, out_nxt;
  logic       emit;
  logic [1:0] len_m1;
  logic       last;

  assign len_m1    = utf8_len_m1(job.value);
  assign emit      = job_avail && (!valid_r || out_take);
  assign last      = (job.kind != JOB_CP) || (idx_r == len_m1);
  assign job_take  = emit && last;
  assign out_valid = valid_r;
  assign out_item  = out_r;

  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    out_nxt   = out_r;
    if (emit) begin
      valid_nxt           = 1'b1;
      idx_nxt             = last ? 2'd0 : idx_r + 2'd1;
      out_nxt.last_of_run = last;
      case (job.kind)
        JOB_RAW: begin
          out_nxt.out_byte = job.value[7:0];
          out_nxt.status   = ST_BYTE;
        end
        JOB_CP: begin
          out_nxt.out_byte = utf8_byte(job.value, len_m1, idx_r);
          out_nxt.status   = ST_BYTE;
        end
        default: begin
          out_nxt.out_byte = 8'h00;
          out_nxt.status   = job.status;
        end
      endcase
    end else if (out_take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  `QSED_ASSERT(a_err_byte_zero, clk, rst_n, (valid_r && out_r.status != ST_BYTE) |-> (out_r.out_byte == 8'h00 && out_r.last_of_run))
  `QSED_ASSERT(a_idx_zero_idle, clk, rst_n, !job_avail |-> idx_r == 2'd0)

endmodule

// ----- rtl/core/quoted_string_escape_decoder_unit.sv -----
`timescale 1ns / 1ps
// The first result of an item reaches out_item through the job queue and then the output register.
// Throughput: one item per cycle while not full; results leave one per cycle while popped, up to four per escape.
// The job queue between decoder and UTF-8 serializer absorbs multi-byte escapes.
// Reset: synchronous, active low; the decoder goes idle and both queues empty.
module quoted_string_escape_decoder_unit #(
  parameter int JOB_DEPTH = qsed_pkg::QSED_JOB_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  qsed_pkg::in_item_t  in_item,
  output logic                empty,
  input  logic                pop,
  output qsed_pkg::out_item_t out_item
);
  import qsed_pkg::*;

  logic accept;
  logic job_valid;
  job_t job_in;
  job_t job_head;
  logic job_empty;
  logic job_take;
  logic out_valid;

  assign accept = push && !full;
  assign empty  = !out_valid;

  qsed_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .item      (in_item),
    .job_valid (job_valid),
    .job       (job_in)
  );

  qsed_fifo #(
    .DEPTH (JOB_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (job_valid),
    .wr_job (job_in),
    .full   (full),
    .rd_en  (job_take),
    .empty  (job_empty),
    .rd_job (job_head)
  );

  qsed_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_avail (!job_empty),
    .job       (job_head),
    .job_take  (job_take),
    .out_valid (out_valid),
    .out_take  (pop),
    .out_item  (out_item)
  );

endmodule
